>>> sv/rc_serial_frame_receiver_unit_macros.svh
// Assertion macros for the serial RC frame receiver.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef RC_SERIAL_FRAME_RECEIVER_UNIT_MACROS_SVH
`define RC_SERIAL_FRAME_RECEIVER_UNIT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define RCSFR_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every rising edge, reset included.
`define RCSFR_ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/rcsfr_pkg.sv
// Shared constants, types and the CRC step for the serial RC frame receiver.
// No dependencies; every other file of the block but the macro header imports this package.
`timescale 1ns / 1ps

package rcsfr_pkg;

   // Frame geometry
   localparam int CHANNELS    = 16;
   localparam int MAX_FRAME   = 40;
   localparam int STORE_DEPTH = 40;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int POS_W       = $clog2(MAX_FRAME + 1);
   localparam int HDR_END     = 6;
   localparam int MIN_LEN     = 8;

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   // Field widths
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;
   localparam int VALUE_W  = 13;

   // Byte codes
   localparam logic [7:0] START_CHANNEL = 8'h3E;
   localparam logic [7:0] START_REQUEST = 8'h3D;
   localparam logic [7:0] HDR2_CHAN_A   = 8'h01;
   localparam logic [7:0] HDR2_CHAN_B   = 8'h03;
   localparam logic [7:0] HDR2_REQUEST  = 8'h01;
   localparam logic [7:0] MAX_GAP_RESET = 8'd1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LEN_ERROR  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CRC_ERROR  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CHANNEL    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_REQUEST_OK = 3'd5;
   localparam logic [STATUS_W-1:0] ST_UNDECODED  = 3'd6;

   // Write into the frame store
   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

   // Work item handed from front to back
   typedef struct packed {
      logic [STATUS_W-1:0] status;
   } cmd_type;

   // One byte of the reflected CRC-16, polynomial 0x8408.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] d;
      d = b ^ crc[7:0];
      d = d ^ {d[3:0], 4'b0};
      return {d, crc[15:8]} ^ {12'b0, d[7:4]} ^ {5'b0, d, 3'b0};
   endfunction

endpackage

>>> sv/rcsfr_channels.sv
// Handshake interfaces for the byte input, the result output and the register port.
// Depends on rcsfr_pkg for field widths.
`timescale 1ns / 1ps

interface rcsfr_req_if;
   import rcsfr_pkg::*;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [31:0] time_ms;
   modport source (output valid, output rx_byte, output time_ms, input ready);
   modport sink (input valid, input rx_byte, input time_ms, output ready);
endinterface

interface rcsfr_rsp_if;
   import rcsfr_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  channel_index;
   logic [VALUE_W-1:0]  channel_value;
   logic                last;
   modport source (output valid, output status, output channel_index,
                   output channel_value, output last, input ready);
   modport sink (input valid, input status, input channel_index,
                 input channel_value, input last, output ready);
endinterface

interface rcsfr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] wr_data;
   modport source (output valid, output wr_data, input ready);
   modport sink (input valid, input wr_data, output ready);
endinterface

>>> sv/rcsfr_front.sv
// Front end: takes bytes, tracks framing, length, CRC and the gap limit,
// writes the frame store and classifies each byte into one command. Uses rcsfr_pkg.
`timescale 1ns / 1ps

module rcsfr_front (
   input  logic                   clock,
   input  logic                   reset,
   rcsfr_req_if.sink              req_ch,
   rcsfr_csr_if.sink              csr_ch,
   input  logic                   q_full,
   input  logic                   chan_done,
   output logic                   cmd_push,
   output rcsfr_pkg::cmd_type     cmd_out,
   output rcsfr_pkg::store_wr_type store_wr
);
   import rcsfr_pkg::*;

   logic [7:0]          max_gap_ff, max_gap_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    len_ff, len_in;
   logic [15:0]         crc_ff, crc_in;
   logic [31:0]         last_time_ff, last_time_in;
   logic                is_chan_ff, is_chan_in;
   logic [7:0]          hdr2_ff, hdr2_in;
   logic [7:0]          len_byte_ff, len_byte_in;
   logic                chan_busy_ff, chan_busy_in;

   logic                accept;
   logic [31:0]         gap;
   logic                restart;
   logic [POS_W-1:0]    pos_cur, len_cur, pos_next, len_next;
   logic                is_start, len_ok, chan_now;
   logic [7:0]          hdr_now;
   logic [15:0]         crc_base;
   logic [STATUS_W-1:0] status;

   // Bytes are held off while a channel frame is being read out of the store.
   assign req_ch.ready = !q_full && !chan_busy_ff;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;

   assign gap      = req_ch.time_ms - last_time_ff;
   assign restart  = gap > 32'(max_gap_ff);
   assign pos_cur  = restart ? '0 : pos_ff;
   assign len_cur  = restart ? POS_W'(MAX_FRAME) : len_ff;
   assign is_start = (req_ch.rx_byte == START_CHANNEL) || (req_ch.rx_byte == START_REQUEST);
   assign len_ok   = (len_byte_ff >= 8'(MIN_LEN)) && (len_byte_ff <= 8'(MAX_FRAME));
   assign pos_next = pos_cur + POS_W'(1);
   assign hdr_now  = (pos_cur == POS_W'(1)) ? req_ch.rx_byte : hdr2_ff;
   assign chan_now = (pos_cur == '0) ? (req_ch.rx_byte == START_CHANNEL) : is_chan_ff;
   assign crc_base = (pos_cur == '0) ? 16'h0000 : crc_ff;

   // Frame tracking for one transfer
   always_comb begin
      pos_in       = pos_ff;
      len_in       = len_ff;
      crc_in       = crc_ff;
      is_chan_in   = is_chan_ff;
      hdr2_in      = hdr2_ff;
      len_byte_in  = len_byte_ff;
      last_time_in = last_time_ff;
      len_next     = len_cur;
      status       = ST_ACCEPTED;
      store_wr.en   = 1'b0;
      store_wr.addr = STORE_AW'(pos_cur);
      store_wr.data = req_ch.rx_byte;
      if (accept) begin
         last_time_in = req_ch.time_ms;
         pos_in       = pos_cur;
         len_in       = len_cur;
         if ((pos_cur == '0) && !is_start) begin
            status = ST_IGNORED;
         end else begin
            is_chan_in  = chan_now;
            hdr2_in     = hdr_now;
            crc_in      = crc_byte(crc_base, req_ch.rx_byte);
            store_wr.en = 1'b1;
            pos_in      = pos_next;
            if (pos_cur == POS_W'(2)) begin
               len_byte_in = req_ch.rx_byte;
            end
            if ((pos_next == POS_W'(HDR_END)) && !len_ok) begin
               status = ST_LEN_ERROR;
               pos_in = '0;
               len_in = POS_W'(MAX_FRAME);
            end else begin
               if (pos_next == POS_W'(HDR_END)) begin
                  len_next = POS_W'(len_byte_ff);
               end
               len_in = len_next;
               if (pos_next == len_next) begin
                  pos_in = '0;
                  len_in = POS_W'(MAX_FRAME);
                  if (crc_in != 16'h0000) begin
                     status = ST_CRC_ERROR;
                  end else if (chan_now &&
                               ((hdr_now == HDR2_CHAN_A) || (hdr_now == HDR2_CHAN_B))) begin
                     status = ST_CHANNEL;
                  end else if (!chan_now && (hdr_now == HDR2_REQUEST)) begin
                     status = ST_REQUEST_OK;
                  end else begin
                     status = ST_UNDECODED;
                  end
               end
            end
         end
      end
   end

   // Busy flag covers the whole channel read-out.
   always_comb begin
      chan_busy_in = chan_busy_ff;
      if (accept && (status == ST_CHANNEL)) begin
         chan_busy_in = 1'b1;
      end else if (chan_done) begin
         chan_busy_in = 1'b0;
      end
   end

   assign max_gap_in     = csr_ch.valid ? csr_ch.wr_data : max_gap_ff;
   assign cmd_push       = accept;
   assign cmd_out.status = status;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff   <= MAX_GAP_RESET;
         pos_ff       <= '0;
         len_ff       <= POS_W'(MAX_FRAME);
         crc_ff       <= '0;
         last_time_ff <= '0;
         is_chan_ff   <= 1'b0;
         hdr2_ff      <= '0;
         len_byte_ff  <= '0;
         chan_busy_ff <= 1'b0;
      end else begin
         max_gap_ff   <= max_gap_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         crc_ff       <= crc_in;
         last_time_ff <= last_time_in;
         is_chan_ff   <= is_chan_in;
         hdr2_ff      <= hdr2_in;
         len_byte_ff  <= len_byte_in;
         chan_busy_ff <= chan_busy_in;
      end
   end

endmodule

>>> sv/rcsfr_queue.sv
// Short command queue between the front and the back end.
// Uses rcsfr_pkg for the command type and depth.
`timescale 1ns / 1ps

module rcsfr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rcsfr_pkg::cmd_type push_data,
   input  logic               pop,
   output rcsfr_pkg::cmd_type head,
   output logic               empty,
   output logic               full
);
   import rcsfr_pkg::*;

   cmd_type        q_mem [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCW'(QDEPTH));
   assign head  = q_mem[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/rcsfr_back.sv
// Back end: holds the frame store, turns commands into results and drives the
// output register, reading channel words out of the store. Uses rcsfr_pkg.
`timescale 1ns / 1ps

module rcsfr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rcsfr_pkg::store_wr_type store_wr,
   input  logic                    q_empty,
   input  rcsfr_pkg::cmd_type      cmd_head,
   output logic                    q_pop,
   output logic                    chan_done,
   rcsfr_rsp_if.source             rsp_ch
);
   import rcsfr_pkg::*;

   localparam logic [1:0] B_IDLE  = 2'd0;
   localparam logic [1:0] B_FETCH = 2'd1;
   localparam logic [1:0] B_SEND  = 2'd2;

   logic [7:0]             store_mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] vld_ff;
   logic [7:0]             rd_lo_ff, rd_hi_ff;
   logic                   rd_lo_vld_ff, rd_hi_vld_ff;

   logic [1:0]          state_ff, state_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [INDEX_W-1:0]  out_index_ff, out_index_in;
   logic [VALUE_W-1:0]  out_value_ff, out_value_in;
   logic                out_last_ff, out_last_in;

   logic [STORE_AW-1:0] addr_lo, addr_hi;
   logic [15:0]         word;
   logic                out_free, load, idx_is_last;

   // Channel i sits at store bytes HDR_END + 2i (low) and the one after (high).
   assign addr_lo = STORE_AW'(HDR_END) + STORE_AW'({idx_ff, 1'b0});
   assign addr_hi = addr_lo + STORE_AW'(1);
   assign word    = {rd_hi_vld_ff ? rd_hi_ff : 8'h00, rd_lo_vld_ff ? rd_lo_ff : 8'h00};

   // Frame store: one write port from the front, two registered read ports
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      rd_lo_ff <= store_mem[addr_lo];
      rd_hi_ff <= store_mem[addr_hi];
   end

   // Entries never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rd_lo_vld_ff <= 1'b0;
         rd_hi_vld_ff <= 1'b0;
      end else begin
         if (store_wr.en) begin
            vld_ff[store_wr.addr] <= 1'b1;
         end
         rd_lo_vld_ff <= vld_ff[addr_lo];
         rd_hi_vld_ff <= vld_ff[addr_hi];
      end
   end

   assign out_free    = !out_valid_ff || rsp_ch.ready;
   assign idx_is_last = (idx_ff == INDEX_W'(CHANNELS - 1));

   // Result sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      q_pop         = 1'b0;
      chan_done     = 1'b0;
      load          = 1'b0;
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (cmd_head.status == ST_CHANNEL) begin
                  q_pop    = 1'b1;
                  idx_in   = '0;
                  state_in = B_FETCH;
               end else if (out_free) begin
                  q_pop         = 1'b1;
                  load          = 1'b1;
                  out_status_in = cmd_head.status;
                  out_index_in  = '0;
                  out_value_in  = '0;
                  out_last_in   = 1'b1;
               end
            end
         end
         B_FETCH: begin
            state_in = B_SEND;
         end
         B_SEND: begin
            if (out_free) begin
               load          = 1'b1;
               out_status_in = ST_CHANNEL;
               out_index_in  = idx_ff;
               out_value_in  = word[15:3];
               out_last_in   = idx_is_last;
               if (idx_is_last) begin
                  chan_done = 1'b1;
                  state_in  = B_IDLE;
               end else begin
                  idx_in   = idx_ff + INDEX_W'(1);
                  state_in = B_FETCH;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign out_valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.status        = out_status_ff;
   assign rsp_ch.channel_index = out_index_ff;
   assign rsp_ch.channel_value = out_value_ff;
   assign rsp_ch.last          = out_last_ff;

endmodule

>>> sv/rc_serial_frame_receiver_unit.sv
// Serial RC frame receiver: each byte taken gives one result,
// except a good channel frame, which gives CHANNELS results. A front end tracks
// framing, the millisecond gap limit, the length byte and the CRC-16 and writes
// each frame byte into a 40-byte frame store; it hands one command per byte through a
// two-entry queue to a back end that drives the registered result port. Single
// results leave at one per cycle while the result port is ready. A channel frame is
// read out one channel at a time (registered store read, then output load), and
// no byte is taken until the last channel is loaded. The store has a valid bit per
// entry cleared by reset, so there is no clearing pass.
// Depends on rcsfr_pkg, the channel interfaces, rcsfr_front, rcsfr_queue and rcsfr_back.
`timescale 1ns / 1ps

module rc_serial_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   rcsfr_req_if.sink   req_ch,
   rcsfr_rsp_if.source rsp_ch,
   rcsfr_csr_if.sink   csr_ch
);
   import rcsfr_pkg::*;

   logic         cmd_push, q_pop, q_empty, q_full, chan_done;
   cmd_type      cmd_in, cmd_head;
   store_wr_type store_wr;

   // Byte intake and classification
   rcsfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .q_full    (q_full),
      .chan_done (chan_done),
      .cmd_push  (cmd_push),
      .cmd_out   (cmd_in),
      .store_wr  (store_wr)
   );

   // Commands waiting for the back end
   rcsfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (q_pop),
      .head      (cmd_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Result generation
   rcsfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .store_wr  (store_wr),
      .q_empty   (q_empty),
      .cmd_head  (cmd_head),
      .q_pop     (q_pop),
      .chan_done (chan_done),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> sv/rcsfr_checker.sv
// Port-level checks on the result channel of the frame receiver, bound to the top level.
// Depends on rcsfr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rc_serial_frame_receiver_unit_macros.svh"

module rcsfr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rcsfr_pkg::STATUS_W-1:0] rsp_status,
   input logic [rcsfr_pkg::INDEX_W-1:0]  rsp_index,
   input logic [rcsfr_pkg::VALUE_W-1:0]  rsp_value,
   input logic                           rsp_last
);
   import rcsfr_pkg::*;

   // A stalled result holds still.
   `RCSFR_ASSERT_RST(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_index) && $stable(rsp_value) && $stable(rsp_last), "stalled result changed")

   // Results other than channel data are single and carry no channel.
   `RCSFR_ASSERT_RST(a_single_form, rsp_valid && (rsp_status != ST_CHANNEL) |-> (rsp_index == '0) && (rsp_value == '0) && rsp_last, "malformed single result")

   // Only the final channel closes a channel frame.
   `RCSFR_ASSERT_RST(a_chan_last, rsp_valid && (rsp_status == ST_CHANNEL) |-> (rsp_last == (rsp_index == INDEX_W'(CHANNELS - 1))), "channel last flag misplaced")

   // No status beyond the defined codes.
   `RCSFR_ASSERT_RST(a_status_range, rsp_valid |-> (rsp_status <= ST_UNDECODED), "undefined status code")

   // Reset leaves no result pending.
   `RCSFR_ASSERT_ANY(a_reset_idle, reset |=> !rsp_valid, "result pending after reset")

endmodule

bind rc_serial_frame_receiver_unit rcsfr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_index  (rsp_ch.channel_index),
   .rsp_value  (rsp_ch.channel_value),
   .rsp_last   (rsp_ch.last)
);

>>> test/rcsfr_test_pkg.sv
// Result record, CRC helper and scoreboard class for the serial RC frame receiver bench.
// Depends on rcsfr_pkg for widths, byte codes and status codes.
`timescale 1ns / 1ps

package rcsfr_test_pkg;
   import rcsfr_pkg::*;

   // One result transfer as it leaves the block.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  channel_index;
      logic [VALUE_W-1:0]  channel_value;
      logic                last;
   } frame_result_type;

   // Reflected CRC-16 with polynomial 0x8408, shifted out one bit at a time.
   function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      return c;
   endfunction

   // Tracks the receiver's framing state and queues the results each byte should give.
   class frame_decode_checker;
      logic [7:0]       gap_limit;
      logic [5:0]       position;
      logic [5:0]       frame_len;
      logic [15:0]      crc;
      logic [31:0]      last_time;
      logic             is_channel;
      logic [7:0]       header_second;
      logic [7:0]       store [STORE_DEPTH];
      frame_result_type awaited [$];
      int               mismatch_count;

      function new();
         gap_limit      = MAX_GAP_RESET;
         position       = '0;
         frame_len      = 6'(MAX_FRAME);
         crc            = '0;
         last_time      = '0;
         is_channel     = 1'b0;
         header_second  = '0;
         mismatch_count = 0;
         foreach (store[k]) store[k] = 8'h00;
      endfunction

      function void set_gap_limit(logic [7:0] v);
         gap_limit = v;
      endfunction

      function bit frame_open();
         return position != 0;
      endfunction

      function void restart();
         position  = '0;
         frame_len = 6'(MAX_FRAME);
      endfunction

      // Every result other than channel data carries zero index and value.
      function void expect_single(logic [STATUS_W-1:0] st);
         frame_result_type r;
         r.status        = st;
         r.channel_index = '0;
         r.channel_value = '0;
         r.last          = 1'b1;
         awaited.push_back(r);
      endfunction

      // Called for each accepted byte transfer.
      function void note_byte(logic [7:0] b, logic [31:0] t);
         logic [31:0]      gap;
         int               p;
         logic [15:0]      word;
         frame_result_type r;
         gap       = t - last_time;
         last_time = t;
         if (gap > {24'h0, gap_limit}) restart();

         // Outside a frame only the two start bytes open one.
         if (position == 0) begin
            if (b == START_CHANNEL) begin
               is_channel = 1'b1;
            end else if (b == START_REQUEST) begin
               is_channel = 1'b0;
            end else begin
               expect_single(ST_IGNORED);
               return;
            end
            crc = '0;
         end

         p = position;
         store[p] = b;
         if (p == 1) header_second = b;
         crc      = crc16_update(crc, b);
         position = 6'(p + 1);

         // The length byte is judged once the header is complete.
         if (position == HDR_END) begin
            if (store[2] >= MIN_LEN && store[2] <= MAX_FRAME) begin
               frame_len = store[2][5:0];
            end else begin
               restart();
               expect_single(ST_LEN_ERROR);
               return;
            end
         end

         if (position != frame_len) begin
            expect_single(ST_ACCEPTED);
            return;
         end

         // Frame complete: the residue and the frame's own header decide the outcome.
         restart();
         if (crc != 0) begin
            expect_single(ST_CRC_ERROR);
         end else if (is_channel &&
                      (header_second == HDR2_CHAN_A || header_second == HDR2_CHAN_B)) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               word            = {store[HDR_END + 2*ch + 1], store[HDR_END + 2*ch]};
               r.status        = ST_CHANNEL;
               r.channel_index = INDEX_W'(ch);
               r.channel_value = word[15:3];
               r.last          = (ch == CHANNELS - 1);
               awaited.push_back(r);
            end
         end else if (!is_channel && header_second == HDR2_REQUEST) begin
            expect_single(ST_REQUEST_OK);
         end else begin
            expect_single(ST_UNDECODED);
         end
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatch_count++;
      endtask

      // Compares one result transfer with the oldest expectation.
      task check_result(frame_result_type got);
         frame_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("result with nothing awaited: status %0d index %0d value %0d last %0d",
                             got.status, got.channel_index, got.channel_value, got.last));
            return;
         end
         want = awaited.pop_front();
         if (got.status != want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.channel_index != want.channel_index)
            report($sformatf("channel_index %0d, expected %0d",
                             got.channel_index, want.channel_index));
         if (got.channel_value != want.channel_value)
            report($sformatf("channel_value %0d, expected %0d",
                             got.channel_value, want.channel_value));
         if (got.last != want.last)
            report($sformatf("last %0d, expected %0d", got.last, want.last));
      endtask
   endclass

endpackage

>>> test/rc_serial_frame_receiver_unit_test.sv
// Bench for the serial RC frame receiver: directed frames, then random well-formed and
// broken frames over several gap limits, with random stalls on both channels.
// Depends on rcsfr_pkg, the channel interfaces, rcsfr_test_pkg and the receiver RTL.
`timescale 1ns / 1ps

module rc_serial_frame_receiver_unit_test;
   import rcsfr_pkg::*;
   import rcsfr_test_pkg::*;

   localparam int IDLE_LIMIT      = 5000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int DRAIN_CYCLES    = 64;
   localparam int HOLD_CYCLES     = 400;
   localparam int ITEMS_PER_PHASE = 56;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rcsfr_req_if req_ch();
   rcsfr_rsp_if rsp_ch();
   rcsfr_csr_if csr_ch();

   frame_decode_checker decode_sb = new();

   logic [7:0]  gap_setting = MAX_GAP_RESET;
   logic [31:0] now_ms = '0;
   int          sent_items = 0;
   bit          hold_wanted = 1'b0;
   int          send_calm = 0;
   int          recv_calm = 0;
   int          idle_cycles = 0;

   rc_serial_frame_receiver_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   // Random wait before a transfer, with occasional runs of no waiting at all.
   function automatic int draw_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   // Next timestamp: within the gap limit, or a break that aborts any open frame.
   function automatic void advance_time(bit broken);
      if (!broken) begin
         now_ms += $urandom_range(0, gap_setting);
      end else begin
         case ($urandom_range(0, 2))
            0: now_ms += {24'h0, gap_setting} + 1 + $urandom_range(0, 5000);
            1: now_ms -= $urandom_range(1, 1000);
            default: now_ms = $urandom();
         endcase
      end
   endfunction

   // One byte transfer on the input channel.
   task automatic send_byte(logic [7:0] b, logic [31:0] t);
      int gap_cycles;
      gap_cycles = draw_wait(send_calm);
      if (gap_cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      req_ch.time_ms <= t;
      do @(posedge clock); while (!req_ch.ready);
      decode_sb.note_byte(b, t);
   endtask

   // Builds a frame with a valid CRC, optionally corrupted, and sends its first nbytes.
   // fill: 0 random payload, 1 all zero, 2 all ones.
   task automatic send_frame(logic [7:0] start, logic [7:0] hdr2, logic [7:0] len,
                             int nbytes, bit corrupt, int fill);
      logic [7:0]  frame_bytes [MAX_FRAME];
      logic [15:0] c;
      int          flen;
      flen = (len >= MIN_LEN && len <= MAX_FRAME) ? int'(len) : MAX_FRAME;
      foreach (frame_bytes[k])
         frame_bytes[k] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
      frame_bytes[0] = start;
      frame_bytes[1] = hdr2;
      frame_bytes[2] = len;
      c = '0;
      for (int k = 0; k < flen - 2; k++) c = crc16_update(c, frame_bytes[k]);
      frame_bytes[flen-2] = c[7:0];
      frame_bytes[flen-1] = c[15:8];
      if (corrupt) frame_bytes[$urandom_range(3, flen - 1)] ^= 8'($urandom_range(1, 255));
      // A frame left open by earlier bytes is closed by a time break first.
      advance_time(decode_sb.frame_open());
      for (int k = 0; k < nbytes; k++) begin
         if (k > 0) advance_time(1'b0);
         send_byte(frame_bytes[k], now_ms);
         sent_items++;
      end
   endtask

   // Register write, only once every awaited result has arrived and the block has settled.
   task automatic write_gap_limit(logic [7:0] v);
      req_ch.valid <= 1'b0;
      while (decode_sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid   <= 1'b1;
      csr_ch.wr_data <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      decode_sb.set_gap_limit(v);
      gap_setting = v;
   endtask

   // Mostly well-formed frames, with bad lengths, cut-off frames and stray bytes mixed in.
   task automatic run_random(int target);
      int         goal;
      int         pick;
      logic [7:0] len;
      logic [7:0] hdr2;
      logic [7:0] start;
      goal = sent_items + target;
      while (sent_items < goal) begin
         pick  = $urandom_range(0, 99);
         start = ($urandom_range(0, 3) == 0) ? START_REQUEST : START_CHANNEL;
         case ($urandom_range(0, 2))
            0: hdr2 = HDR2_CHAN_A;
            1: hdr2 = HDR2_CHAN_B;
            default: hdr2 = 8'($urandom);
         endcase
         if (pick < 55) begin
            len = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(MIN_LEN, 14))
                                             : 8'($urandom_range(15, MAX_FRAME));
            send_frame(start, hdr2, len, len, $urandom_range(0, 5) == 0,
                       ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
         end else if (pick < 67) begin
            len = $urandom_range(0, 1) ? 8'($urandom_range(0, MIN_LEN - 1))
                                       : 8'($urandom_range(MAX_FRAME + 1, 255));
            send_frame(start, hdr2, len, HDR_END, 1'b0, 0);
         end else if (pick < 80) begin
            len = 8'($urandom_range(MIN_LEN, 20));
            send_frame(start, hdr2, len, $urandom_range(1, len - 1), 1'b0, 0);
         end else begin
            advance_time($urandom_range(0, 3) == 0);
            send_byte(8'($urandom), now_ms);
            sent_items++;
         end
      end
   endtask

   // Result checking on every accepted result transfer.
   always @(posedge clock) begin : result_monitor
      frame_result_type seen;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.status        = rsp_ch.status;
         seen.channel_index = rsp_ch.channel_index;
         seen.channel_value = rsp_ch.channel_value;
         seen.last          = rsp_ch.last;
         decode_sb.check_result(seen);
      end
   end

   // Watchdog: too long without any transfer on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off so that the block backs up.
   initial begin : result_sink
      int hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_wanted) begin
            hold        = HOLD_CYCLES;
            hold_wanted = 1'b0;
         end else begin
            hold = draw_wait(recv_calm);
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Stimulus and the final verdict.
   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      req_ch.time_ms <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.wr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset gap limit: stray bytes, a short channel frame whose
      // timestamps wrap and whose channels come from the cleared store, a request frame
      // and a frame with an out-of-range length byte.
      now_ms = 32'd5;
      send_byte(8'hFF, now_ms);
      now_ms = 32'hFFFF_FFFE;
      send_byte(8'h00, now_ms);
      send_frame(START_CHANNEL, HDR2_CHAN_B, 8'(MIN_LEN), MIN_LEN, 1'b0, 0);
      send_frame(START_REQUEST, HDR2_REQUEST, 8'(MIN_LEN), MIN_LEN, 1'b0, 2);
      send_frame(START_CHANNEL, HDR2_CHAN_A, 8'hFF, HDR_END, 1'b0, 1);

      run_random(ITEMS_PER_PHASE);
      write_gap_limit(8'd0);
      run_random(ITEMS_PER_PHASE);
      write_gap_limit(8'd255);
      hold_wanted = 1'b1;
      run_random(ITEMS_PER_PHASE);
      write_gap_limit(8'($urandom_range(2, 254)));
      run_random(ITEMS_PER_PHASE);
      write_gap_limit(MAX_GAP_RESET);
      run_random(ITEMS_PER_PHASE);

      req_ch.valid <= 1'b0;
      while (decode_sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decode_sb.mismatch_count == 0 && decode_sb.awaited.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/rcsfr_pkg.sv
sv/rcsfr_channels.sv
sv/rcsfr_front.sv
sv/rcsfr_queue.sv
sv/rcsfr_back.sv
sv/rc_serial_frame_receiver_unit.sv
sv/rcsfr_checker.sv
test/rcsfr_test_pkg.sv
test/rc_serial_frame_receiver_unit_test.sv
